@@ hdl/fir10_pkg.sv @@
package fir10_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS = 16;
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int OUT_BITS = 35;
  localparam int OUT_TDATA_BITS = 40;

  localparam int TAPS_DEFAULT = 10;
  localparam int TAPS_MAX = 12;
  localparam int FILL_BITS = 4;

  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS = 2;
  localparam int NUM_COEF_REGS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_COEFFS_LOW = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEFFS_MID = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COEFFS_HIGH = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [OUT_BITS-1:0] acc_t;

endpackage

@@ hdl/fir_filter_10_tap_unit.sv @@
// Direct-form FIR filter with TAPS taps (10 by default, 1 to 12) on signed Q1.15 samples and
// coefficients, giving an unrounded signed Q5.30 sum of 35 bits on out_tdata. Coefficients are
// three 64-bit registers on the APB port at byte addresses 0, 8 and 16, four taps each, tap 0
// in the lowest half-word; write them only while the filter is idle. A request with the start
// flag (in_tuser) restarts the window, and no result comes out until TAPS samples of the signal
// have been taken; until then each sample is accepted without a stall. Once the window is full,
// each sample runs through one shared 16x16 multiply-accumulate unit, one tap per cycle, so
// in_tready stays low from that sample until the result is loaded into the output register.
// The result then sits there, so the next sample is accepted while it waits; a stalled output
// only holds the filter once the following result is ready. out_tlast copies the end flag
// (in_tlast) of the sample that produced the result.
module fir_filter_10_tap_unit #(
  parameter int TAPS = fir10_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample [15:0]
  input  logic [fir10_pkg::SAMPLE_BITS-1:0]     in_tdata,
  // start_of_signal
  input  logic                                  in_tuser,
  input  logic                                  in_tlast,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // filtered [34:0], zero fill [39:35]
  output logic [fir10_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [fir10_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [fir10_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [fir10_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);
  import fir10_pkg::*;

  localparam int JW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [JW-1:0] LAST_TAP = JW'(TAPS - 1);
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(TAPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration
  logic [CFG_DATA_BITS-1:0] coeff_r [NUM_COEF_REGS];
  logic [NUM_COEF_REGS*CFG_DATA_BITS-1:0] coeff_flat;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic cfg_wr;

  // sequencer and datapath
  logic [1:0] state_r, state_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  sample_t win_r [TAPS];
  acc_t acc_r, acc_nxt;
  logic last_r;
  logic out_valid_r, out_valid_nxt;
  acc_t out_data_r;
  logic out_last_r;

  logic in_acc;
  logic emit;
  logic out_load;
  logic [FILL_BITS-1:0] fill_base;
  coef_t coef_sel;
  sample_t win_sel;
  prod_t prod;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[CFG_ADDR_BITS-1 -: REG_IDX_BITS];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign coeff_flat = {coeff_r[2], coeff_r[1], coeff_r[0]};

  always_comb begin
    unique case (reg_idx)
      REG_COEFFS_LOW:  cfg_prdata = coeff_r[0];
      REG_COEFFS_MID:  cfg_prdata = coeff_r[1];
      REG_COEFFS_HIGH: cfg_prdata = coeff_r[2];
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COEFFS_LOW:  coeff_r[0] <= cfg_pwdata;
        REG_COEFFS_MID:  coeff_r[1] <= cfg_pwdata;
        REG_COEFFS_HIGH: coeff_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign fill_base = in_tuser ? '0 : fill_r;
  assign emit = (fill_base >= FILL_FULL);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // shared multiply-accumulate unit
  assign coef_sel = coeff_flat[COEF_BITS*j_r +: COEF_BITS];
  assign win_sel = win_r[j_r];
  assign prod = coef_sel * win_sel;
  assign acc_nxt = acc_r + OUT_BITS'(prod);

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    fill_nxt = fill_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          j_nxt = '0;
          if (emit) begin
            fill_nxt = fill_base;
            state_nxt = ST_MAC;
          end else begin
            fill_nxt = fill_base + FILL_BITS'(1);
          end
        end
      end
      ST_MAC: begin
        j_nxt = j_r + JW'(1);
        if (j_r == LAST_TAP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r <= '0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r <= j_nxt;
      fill_r <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window: entry 0 is the newest sample
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r[0] <= sample_t'(in_tdata);
      for (int k = 1; k < TAPS; k++) begin
        win_r[k] <= win_r[k-1];
      end
      last_r <= in_tlast;
      acc_r <= '0;
    end else if (state_r == ST_MAC) begin
      acc_r <= acc_nxt;
    end
    if (out_load) begin
      out_data_r <= acc_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, out_data_r};
  assign out_tlast = out_last_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> j_r <= LAST_TAP)
    else $error("tap index beyond last tap");

  a_emit_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> state_r == ST_MAC && j_r == '0)
    else $error("full window did not start the accumulation");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished result not presented");

  a_no_emit_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !emit |=> state_r == ST_IDLE && fill_r == $past(fill_base) + FILL_BITS'(1))
    else $error("partial window mishandled");
`endif

endmodule
